### rtl/fbdrt_pkg.sv
// Shared types and constants for the framebuffer dirty-rectangle tracker.
package fbdrt_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PIXB   = 2'd2;

  localparam logic [12:0] DIM_MAX  = 13'd4096;
  localparam logic [3:0]  PIXB_MAX = 4'd8;

  localparam int DVD_W = 24;
  localparam int DVS_W = 13;

endpackage

### rtl/fbdrt_ram.sv
// Generic single-port synchronous RAM with registered read data.
module fbdrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/fbdrt_div.sv
// Restoring divider that produces one quotient bit per cycle.
module fbdrt_div
  import fbdrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[DVD_W-1]};
    if (go_i) begin
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(trial - {1'b0, dvs_q});
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

### rtl/framebuffer_dirty_rect_tracker_unit.sv
// Top level of the framebuffer dirty-rectangle tracker: sequencer, box and counters.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  command | in        | start && !busy      | op_i, offset_i, size_code_i, write_data_i
//  result  | out       | done_o (one cycle)  | read_data_o, fault_o, dirty_*_o, *_total_o
//  config  | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// Clear and unused commands and faults end at the bounds check, reads pass through the
// byte memory, and writes run four divisions on the shared bit-serial divider, which sets the write time.
// The byte memory has one port, so an access moves its bytes one at a time.
// After reset a clearing pass zeroes every byte of the memory with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module framebuffer_dirty_rect_tracker_unit
  import fbdrt_pkg::*;
#(
  parameter int MEM_BYTES = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [23:0] offset_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] write_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  output logic        done_o,
  output logic [63:0] read_data_o,
  output logic        fault_o,
  output logic        dirty_flag_o,
  output logic [12:0] dirty_left_o,
  output logic [12:0] dirty_top_o,
  output logic [12:0] dirty_cols_o,
  output logic [12:0] dirty_rows_o,
  output logic [31:0] write_total_o,
  output logic [31:0] bytes_total_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [24:0] MemLimit = 25'(MEM_BYTES);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_FB1   = 4'd2;
  localparam logic [3:0] ST_FB2   = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_MEM   = 4'd5;
  localparam logic [3:0] ST_RDW   = 4'd6;
  localparam logic [3:0] ST_RDF   = 4'd7;
  localparam logic [3:0] ST_DIVGO = 4'd8;
  localparam logic [3:0] ST_DIVWT = 4'd9;
  localparam logic [3:0] ST_MERGE = 4'd10;

  logic [3:0]  state_q;
  logic [12:0] width_q, height_q;
  logic [3:0]  pixb_q;
  logic [1:0]  op_q, size_q;
  logic [23:0] off_q;
  logic [63:0] wdata_q;
  logic [25:0] wh_q;
  logic [29:0] fb_q;
  logic [24:0] end_q;
  logic [2:0]  idx_q;
  logic [AW-1:0] clr_addr_q;
  logic        rd_pend_q;
  logic [2:0]  rd_lane_q;
  logic [63:0] rd_q;
  logic [1:0]  phase_q;
  logic [23:0] p0_q, p1_q;
  logic [12:0] x0_q, y0_q, x1_q, y1_q;
  logic [12:0] box_l_q, box_t_q, box_c_q, box_r_q;
  logic [31:0] wr_cnt_q, byte_cnt_q;
  logic        done_q, fault_q;
  logic [63:0] rdata_out_q;

  logic          accept;
  logic [3:0]    len;
  logic [2:0]    last_idx;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [24:0]   addr_sum;
  logic          acc_ok;
  logic          div_go, div_done;
  logic [23:0]   div_dvd, div_q;
  logic [12:0]   div_dvs, div_r;
  logic [12:0]   nx, ny, nw, nh;
  logic [13:0]   r1, r2, b1, b2, rr, bb;
  logic [12:0]   ml, mt;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign len      = 4'd1 << size_q;
  assign last_idx = 3'(len - 4'd1);
  assign addr_sum = {1'b0, off_q} + {22'd0, idx_q};
  assign acc_ok   = ({5'd0, end_q} <= fb_q) && (end_q <= MemLimit);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_sum[AW-1:0];
    ram_wdata = wdata_q[{idx_q, 3'b000} +: 8];
    if (state_q == ST_CLR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr_q;
      ram_wdata = '0;
    end else if (state_q == ST_MEM && op_q == OP_WRITE) begin
      ram_we = 1'b1;
    end
  end

  fbdrt_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    div_go = (state_q == ST_DIVGO);
    case (phase_q)
      2'd0: begin
        div_dvd = off_q;
        div_dvs = {9'd0, pixb_q};
      end
      2'd1: begin
        div_dvd = 24'(end_q - 25'd1);
        div_dvs = {9'd0, pixb_q};
      end
      2'd2: begin
        div_dvd = p0_q;
        div_dvs = width_q;
      end
      default: begin
        div_dvd = p1_q;
        div_dvs = width_q;
      end
    endcase
  end

  fbdrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // Rectangle of this write and its merge into the bounding box.
  always_comb begin
    if (y0_q == y1_q) begin
      nx = x0_q;
      nw = 13'(x1_q - x0_q + 13'd1);
      nh = 13'd1;
    end else begin
      nx = '0;
      nw = width_q;
      nh = 13'(y1_q - y0_q + 13'd1);
    end
    ny = y0_q;
    ml = (box_l_q < nx) ? box_l_q : nx;
    mt = (box_t_q < ny) ? box_t_q : ny;
    r1 = {1'b0, box_l_q} + {1'b0, box_c_q};
    r2 = {1'b0, nx} + {1'b0, nw};
    b1 = {1'b0, box_t_q} + {1'b0, box_r_q};
    b2 = {1'b0, ny} + {1'b0, nh};
    rr = (r1 > r2) ? r1 : r2;
    bb = (b1 > b2) ? b1 : b2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_addr_q <= '0;
      width_q    <= 13'd320;
      height_q   <= 13'd240;
      pixb_q     <= 4'd4;
      box_l_q    <= '0;
      box_t_q    <= '0;
      box_c_q    <= '0;
      box_r_q    <= '0;
      wr_cnt_q   <= '0;
      byte_cnt_q <= '0;
      done_q     <= 1'b0;
      rd_pend_q  <= 1'b0;
      idx_q      <= '0;
      phase_q    <= '0;
    end else begin
      done_q    <= 1'b0;
      rd_pend_q <= (state_q == ST_MEM) && (op_q == OP_READ);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:  width_q  <= (cfg_data_i > DIM_MAX) ? DIM_MAX : cfg_data_i;
          REG_HEIGHT: height_q <= (cfg_data_i > DIM_MAX) ? DIM_MAX : cfg_data_i;
          REG_PIXB:   pixb_q   <= (cfg_data_i[3:0] > PIXB_MAX) ? PIXB_MAX : cfg_data_i[3:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(MEM_BYTES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_FB1;
          end
        end
        ST_FB1: state_q <= ST_FB2;
        ST_FB2: state_q <= ST_CHK;
        ST_CHK: begin
          idx_q   <= '0;
          phase_q <= '0;
          if ((op_q == OP_READ || op_q == OP_WRITE) && acc_ok) begin
            state_q <= ST_MEM;
          end else begin
            if (op_q == OP_CLEAR) begin
              box_l_q <= '0;
              box_t_q <= '0;
              box_c_q <= '0;
              box_r_q <= '0;
            end
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_MEM: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == last_idx) begin
            state_q <= (op_q == OP_READ) ? ST_RDW : ST_DIVGO;
          end
        end
        ST_RDW: state_q <= ST_RDF;
        ST_RDF: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_DIVGO: state_q <= ST_DIVWT;
        ST_DIVWT: begin
          if (div_done) begin
            phase_q <= phase_q + 1'b1;
            state_q <= (phase_q == 2'd3) ? ST_MERGE : ST_DIVGO;
          end
        end
        ST_MERGE: begin
          if (box_c_q == '0) begin
            box_l_q <= nx;
            box_t_q <= ny;
            box_c_q <= nw;
            box_r_q <= nh;
          end else begin
            box_l_q <= ml;
            box_t_q <= mt;
            box_c_q <= 13'(rr - {1'b0, ml});
            box_r_q <= 13'(bb - {1'b0, mt});
          end
          wr_cnt_q   <= wr_cnt_q + 32'd1;
          byte_cnt_q <= byte_cnt_q + {28'd0, len};
          done_q     <= 1'b1;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload, read-assembly, bound, division-result and output registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      off_q   <= offset_i;
      size_q  <= size_code_i;
      wdata_q <= write_data_i;
      rd_q    <= '0;
    end else if (rd_pend_q) begin
      rd_q[{rd_lane_q, 3'b000} +: 8] <= ram_rdata;
    end
    rd_lane_q <= idx_q;
    if (state_q == ST_FB1) begin
      wh_q  <= {13'd0, width_q} * {13'd0, height_q};
      end_q <= {1'b0, off_q} + {21'd0, len};
    end
    if (state_q == ST_FB2) begin
      fb_q <= {4'd0, wh_q} * {26'd0, pixb_q};
    end
    if (state_q == ST_DIVWT && div_done) begin
      case (phase_q)
        2'd0: p0_q <= div_q;
        2'd1: p1_q <= div_q;
        2'd2: begin
          y0_q <= div_q[12:0];
          x0_q <= div_r;
        end
        default: begin
          y1_q <= div_q[12:0];
          x1_q <= div_r;
        end
      endcase
    end
    if (state_q == ST_CHK) begin
      fault_q     <= (op_q == OP_READ || op_q == OP_WRITE) && !acc_ok;
      rdata_out_q <= '0;
    end else if (state_q == ST_RDF) begin
      fault_q     <= 1'b0;
      rdata_out_q <= rd_q;
    end else if (state_q == ST_MERGE) begin
      fault_q     <= 1'b0;
      rdata_out_q <= '0;
    end
  end

  assign done_o        = done_q;
  assign read_data_o   = rdata_out_q;
  assign fault_o       = fault_q;
  assign dirty_flag_o  = (box_c_q != '0);
  assign dirty_left_o  = box_l_q;
  assign dirty_top_o   = box_t_q;
  assign dirty_cols_o  = box_c_q;
  assign dirty_rows_o  = box_r_q;
  assign write_total_o = wr_cnt_q;
  assign bytes_total_o = byte_cnt_q;

endmodule

### rtl/fbdrt_checker.sv
// Port-level assertions for the tracker and the bind that attaches them.
module fbdrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [63:0] read_data_o,
  input logic        fault_o,
  input logic        dirty_flag_o,
  input logic [12:0] dirty_cols_o,
  input logic [31:0] write_total_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fault_o) |-> (read_data_o == 64'd0))
    else $error("faulted transaction returned data");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dirty_flag_o == (dirty_cols_o != 13'd0)))
    else $error("dirty flag disagrees with box width");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fault_o) |-> (write_total_o == $past(write_total_o)))
    else $error("faulted write changed the write count");

endmodule

bind framebuffer_dirty_rect_tracker_unit fbdrt_checker u_fbdrt_checker (.*);
